// File: rtl/core/wmms_pkg.sv
`default_nettype none
package wmms_pkg;

    // default window depth
    localparam int MAX_WINDOW_DEF = 16;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int WIN_W    = 5;
    localparam int COUNT_W  = 5;

    // configuration register indexes
    localparam logic CFG_IDX_WINDOW = 1'b0;
    localparam logic CFG_IDX_THRESH = 1'b1;

    // item op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // control for the sorting cells
    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_sort_ctl;

endpackage
`default_nettype wire

// File: rtl/core/wmms_sort_cell.sv
`default_nettype none
module wmms_sort_cell
    import wmms_pkg::*;
(
    input  wire                        i_clk,
    input  wire t_sort_ctl             i_ctl,
    input  wire                        i_first,
    input  wire signed [SAMPLE_W-1:0]  i_x,
    input  wire signed [SAMPLE_W-1:0]  i_prev_val,
    input  wire                        i_prev_vld,
    input  wire signed [SAMPLE_W-1:0]  i_next_val,
    input  wire                        i_next_vld,
    output logic signed [SAMPLE_W-1:0] o_val,
    output logic                       o_vld
);

    logic signed [SAMPLE_W-1:0] r_val;
    logic                       r_vld;
    logic signed [SAMPLE_W-1:0] n_val;
    logic                       n_vld;

    // clear, insertion into an ascending row, or shift toward the head
    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.clear) begin
            n_vld = 1'b0;
        end else if (i_ctl.insert) begin
            if (r_vld && (r_val <= i_x)) begin
                n_val = r_val;
            end else if (i_first || (i_prev_vld && (i_prev_val <= i_x))) begin
                n_val = i_x;
                n_vld = 1'b1;
            end else begin
                n_val = i_prev_val;
                n_vld = i_prev_vld;
            end
        end else if (i_ctl.shift) begin
            n_val = i_next_val;
            n_vld = i_next_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_vld <= n_vld;
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule
`default_nettype wire

// File: rtl/core/wmms_div.sv
`default_nettype none
module wmms_div
    import wmms_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 5
) (
    input  wire              i_clk,
    input  wire              i_start,
    input  wire              i_step,
    input  wire [NUM_W-1:0]  i_dividend,
    input  wire [DEN_W-1:0]  i_divisor,
    output logic [NUM_W-1:0] o_quot
);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;
    logic [DEN_W:0]   rem_sub;

    // one restoring step: bring down one dividend bit
    always_comb begin
        rem_sh  = {r_rem, r_q[NUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (i_step) begin
            r_q   <= {r_q[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_quot = r_q;

endmodule
`default_nettype wire

// File: rtl/core/windowed_mean_median_stability.sv
`default_nettype none
// Windowed mean, median and stability filter. Each sample item stores the
// sample in a ring of MAX_WINDOW cells (overwriting the oldest once the window
// is full) and returns one result item: truncated mean, median (floor average
// of the middle pair for an even count), a stability flag and the fill count.
// A clear item empties the window and returns zeros. For a sample item, one
// rotation of the ring fills the sorting row and the sum, and a second
// rotation reads the sorted row and checks every deviation while a bit-serial
// divider forms the mean. A new item is taken while the previous result waits
// in the output register.
// Configuration must only be written while the block is idle.
module windowed_mean_median_stability
    import wmms_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] sample
    input  wire         s_axis_tuser,   // [0] op
    // result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // [15:0] mean_value, [31:16] median_value,
                                        // [32] is_stable, [37:33] fill_count
);

    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int SW   = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int NCYC = (MAX_WINDOW > SW) ? MAX_WINDOW : SW;
    localparam int KW   = $clog2(NCYC + 1);
    localparam int DW   = SW + CW + 2;
    localparam int LW   = CW + CFG_W;
    localparam int EW   = (CW > WIN_W) ? CW : WIN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_PREP,
        S_PASS2,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [WIN_W-1:0]            r_win;
    logic [CFG_W-1:0]            r_thr;
    logic signed [SAMPLE_W-1:0]  r_ring [MAX_WINDOW];
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               r_pos;
    logic [CW-1:0]               r_tgt;
    logic [CW-1:0]               r_n;
    logic [KW-1:0]               r_k;
    logic                        r_clr;
    logic signed [SAMPLE_W-1:0]  r_v;
    logic signed [SW-1:0]        r_sum;
    logic [LW-1:0]               r_lim;
    logic                        r_stable;
    logic signed [SAMPLE_W-1:0]  r_lo;
    logic signed [SAMPLE_W-1:0]  r_hi;
    logic                        r_out_vld;
    logic [39:0]                 r_out;

    logic [CW-1:0]               len;
    logic [CW-1:0]               pos_e;
    logic                        not_full;
    logic signed [SAMPLE_W-1:0]  head_eff;
    logic                        k_in_ring;
    logic                        k_in_cnt;
    t_sort_ctl                   sort_ctl;
    logic signed [SAMPLE_W-1:0]  sort_val [MAX_WINDOW];
    logic                        sort_vld [MAX_WINDOW];
    logic [SW-1:0]               sum_mag;
    logic [SW-1:0]               quot;
    logic signed [DW-1:0]        dev;
    logic [DW-1:0]               dev_mag;
    logic signed [SAMPLE_W:0]    mid_sum;
    logic signed [SW-1:0]        mean_full;
    logic [CW-1:0]               lo_idx;
    logic [CW-1:0]               hi_idx;
    logic [39:0]                 res;
    logic                        accept;

    // effective window length, clamped to 1..MAX_WINDOW
    always_comb begin
        if (r_win == '0) begin
            len = CW'(1);
        end else if (EW'(r_win) > EW'(MAX_WINDOW)) begin
            len = CW'(MAX_WINDOW);
        end else begin
            len = CW'(r_win);
        end
        pos_e    = (r_pos < len) ? r_pos : '0;
        not_full = (r_cnt < len);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // per-cycle sequencing of the two ring passes
    always_comb begin
        k_in_ring = (int'(r_k) < MAX_WINDOW);
        k_in_cnt  = (int'(r_k) < int'(r_n));
        head_eff  = ((r_state == S_PASS1) && (int'(r_k) == int'(r_tgt))) ? r_v : r_ring[0];
        sort_ctl.clear  = accept;
        sort_ctl.insert = (r_state == S_PASS1) && k_in_cnt;
        sort_ctl.shift  = (r_state == S_PASS2) && k_in_ring;
        lo_idx = CW'((r_n - CW'(1)) >> 1);
        hi_idx = r_n >> 1;
    end

    // row of sorting cells
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_sort
        wmms_sort_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (sort_ctl),
            .i_first    (g == 0),
            .i_x        (head_eff),
            .i_prev_val ((g == 0) ? sort_val[0] : sort_val[(g == 0) ? 0 : g-1]),
            .i_prev_vld ((g == 0) ? 1'b0 : sort_vld[(g == 0) ? 0 : g-1]),
            .i_next_val ((g == MAX_WINDOW-1) ? sort_val[g] :
                         sort_val[(g == MAX_WINDOW-1) ? g : g+1]),
            .i_next_vld ((g == MAX_WINDOW-1) ? 1'b0 :
                         sort_vld[(g == MAX_WINDOW-1) ? g : g+1]),
            .o_val      (sort_val[g]),
            .o_vld      (sort_vld[g])
        );
    end

    // magnitude of the sum for the divider
    assign sum_mag = (r_sum < 0) ? SW'(-r_sum) : SW'(r_sum);

    wmms_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_start    (r_state == S_PREP),
        .i_step     ((r_state == S_PASS2) && (int'(r_k) < SW)),
        .i_dividend (sum_mag),
        .i_divisor  (r_n),
        .o_quot     (quot)
    );

    // deviation of the head sample from the mean, scaled by the count
    always_comb begin
        dev     = DW'($signed({1'b0, r_n})) * DW'(r_ring[0]) - DW'(r_sum);
        dev_mag = (dev < 0) ? DW'(-dev) : DW'(dev);
    end

    // result fields
    always_comb begin
        mid_sum   = (SAMPLE_W+1)'(r_lo) + (SAMPLE_W+1)'(r_hi);
        mean_full = (r_sum < 0) ? SW'(-$signed(quot)) : SW'($signed(quot));
        if (r_clr) begin
            res = '0;
        end else begin
            res = {2'b00, COUNT_W'(r_n), r_stable,
                   mid_sum[SAMPLE_W:1], mean_full[SAMPLE_W-1:0]};
        end
    end

    // ring of sample cells, rotated toward the head during both passes
    always_ff @(posedge i_clk) begin
        if (((r_state == S_PASS1) || (r_state == S_PASS2)) && k_in_ring) begin
            for (int i = 0; i < MAX_WINDOW - 1; i++) begin
                r_ring[i] <= r_ring[i+1];
            end
            r_ring[MAX_WINDOW-1] <= head_eff;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_W'(16);
            r_thr <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_IDX_WINDOW: r_win <= i_cfg_data[WIN_W-1:0];
                CFG_IDX_THRESH: r_thr <= i_cfg_data;
                default:        r_thr <= r_thr;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pos     <= '0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // output drained; the done state refills it on its own
            if (r_out_vld && m_axis_tready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_v   <= $signed(s_axis_tdata);
                        r_k   <= '0;
                        r_sum <= '0;
                        if (s_axis_tuser == OP_CLEAR) begin
                            r_clr   <= 1'b1;
                            r_cnt   <= '0;
                            r_pos   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_clr   <= 1'b0;
                            r_tgt   <= not_full ? r_cnt : pos_e;
                            r_n     <= not_full ? r_cnt + CW'(1) : r_cnt;
                            r_cnt   <= not_full ? r_cnt + CW'(1) : r_cnt;
                            r_pos   <= (pos_e + CW'(1) == len) ? '0 : pos_e + CW'(1);
                            r_state <= S_PASS1;
                        end
                    end
                end
                S_PASS1: begin
                    if (k_in_cnt) begin
                        r_sum <= r_sum + SW'(head_eff);
                    end
                    if (int'(r_k) == MAX_WINDOW - 1) begin
                        r_state <= S_PREP;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_PREP: begin
                    r_k      <= '0;
                    r_lim    <= LW'(r_n) * LW'(r_thr);
                    r_stable <= (r_n >= CW'(2));
                    r_state  <= S_PASS2;
                end
                S_PASS2: begin
                    if (k_in_ring && k_in_cnt && (dev_mag > DW'(r_lim))) begin
                        r_stable <= 1'b0;
                    end
                    if (r_k == KW'(lo_idx)) begin
                        r_lo <= sort_val[0];
                    end
                    if (r_k == KW'(hi_idx)) begin
                        r_hi <= sort_val[0];
                    end
                    if (int'(r_k) == NCYC - 1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out     <= res;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // fill count never exceeds the ring depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= MAX_WINDOW)
        else $error("fill count beyond ring depth");

    // a stable result always covers at least two samples
    a_stable_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[37:33] >= 5'd2))
        else $error("stable flag with fewer than two samples");

    // a clear item leaves the window empty
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == OP_CLEAR)) |=> (r_cnt == '0) && (r_pos == '0))
        else $error("clear did not empty the window");

endmodule
`default_nettype wire
